FILE: src/cpfv_pkg.sv
package cpfv_pkg;

    localparam int unsigned CPF_LENGTH = 14;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = 2;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CPF_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_SAT    = 4'd15;
    localparam logic [POS_W-1:0] POS_DOT_A  = 4'd3;
    localparam logic [POS_W-1:0] POS_DOT_B  = 4'd7;
    localparam logic [POS_W-1:0] POS_HYPHEN = 4'd11;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] MOD_VAL     = 4'd11;
    localparam logic [3:0] DIGIT_TOTAL = 4'd11;
    localparam logic [3:0] IDX_FIRST   = 4'd8;
    localparam logic [3:0] IDX_SECOND  = 4'd9;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_CHECK  = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } t_in_word;

    typedef struct packed {
        logic       valid_res;
        logic [1:0] error_code;
    } t_out_word;

    // classified character, as handed from front to back
    typedef struct packed {
        logic       last;
        logic       ok_char;
        logic       digit_ok;
        logic       end_ok;
        logic [3:0] dval;
    } t_cls_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // a + b mod 11, both operands at most 10
    function automatic logic [3:0] mod11_add(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MOD_VAL}) begin
            s = s - {1'b0, MOD_VAL};
        end
        return s[3:0];
    endfunction

    // (10 * sum) mod 11 from r = sum mod 11; a remainder of 10 reads as 0
    function automatic logic [3:0] check_value(input logic [3:0] r);
        logic [3:0] v;
        if (r <= 4'd1) begin
            v = 4'd0;
        end else begin
            v = MOD_VAL - r;
        end
        return v;
    endfunction

endpackage

FILE: src/cpf_number_validator_top.sv
// CPF number validator.
// Input channel: one ASCII character of the text NNN.NNN.NNN-NN per word, with
// final_char set on the last one. A word is taken at a clock edge where
// i_in_valid is high and o_in_stall is low.
// Output channel: one word per string, on its final character: valid_res and
// error_code (0 ok, 1 bad format or length, 2 bad check digits). A word is
// taken where o_out_valid is high and i_out_stall is low.
// Throughput: one character per cycle while not stalled, strings back to back.
// Path: the final character is written into the four-entry queue, then passes
// through the checker into the output register.
// When the receiver stalls, the result holds in the output register; the
// checker keeps draining characters of the next string until it meets its
// final one, then the queue fills and o_in_stall rises.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending result
// and clears the position counter and the running sums.
module cpf_number_validator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cpfv_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output cpfv_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import cpfv_pkg::*;

    logic      push;
    logic      pop;
    t_cls_word front_cls;
    t_cls_word head_cls;
    t_q_status q_status;

    assign o_in_stall = q_status.full;
    assign push       = i_in_valid && !q_status.full;

    cpfv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (i_in_word),
        .o_cls   (front_cls)
    );

    cpfv_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (front_cls),
        .i_pop    (pop),
        .o_word   (head_cls),
        .o_status (q_status)
    );

    cpfv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_status.empty),
        .i_cls       (head_cls),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    a_res_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.valid_res == (o_out_word.error_code == ERR_OK)) &&
                        (o_out_word.error_code != 2'd3))
        else $error("result flag disagrees with error code");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !q_status.full)
        else $error("reset left a result or a full queue");

endmodule

FILE: src/cpfv_front.sv
module cpfv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cpfv_pkg::t_in_word i_word,
    output cpfv_pkg::t_cls_word o_cls
);
    import cpfv_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             is_digit;

    assign is_digit = (i_word.character >= CH_ZERO) && (i_word.character <= CH_NINE);

    always_comb begin
        o_cls.last     = i_word.final_char;
        o_cls.end_ok   = (r_pos == POS_LAST);
        o_cls.digit_ok = 1'b0;
        o_cls.dval     = 4'd0;
        if (r_pos >= POS_W'(CPF_LENGTH)) begin
            o_cls.ok_char = 1'b0;
        end else if (r_pos == POS_DOT_A || r_pos == POS_DOT_B) begin
            o_cls.ok_char = (i_word.character == CH_DOT);
        end else if (r_pos == POS_HYPHEN) begin
            o_cls.ok_char = (i_word.character == CH_HYPHEN);
        end else begin
            o_cls.ok_char  = is_digit;
            o_cls.digit_ok = is_digit;
            if (is_digit) begin
                o_cls.dval = i_word.character[3:0];
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_push) begin
            if (i_word.final_char) begin
                n_pos = '0;
            end else if (r_pos != POS_SAT) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: src/cpfv_queue.sv
module cpfv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cpfv_pkg::t_cls_word i_word,
    input  logic                i_pop,
    output cpfv_pkg::t_cls_word o_word,
    output cpfv_pkg::t_q_status o_status
);
    import cpfv_pkg::*;

    t_cls_word       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_word          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/cpfv_back.sv
module cpfv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cpfv_pkg::t_cls_word i_cls,
    output logic                o_pop,
    output logic                o_out_valid,
    output cpfv_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import cpfv_pkg::*;

    // Weighted sums are kept mod 11 as a running prefix p and a sum of prefixes t;
    // t + p then carries weights from the digit count plus one down to 2.
    logic       r_fmt;
    logic [3:0] r_dcnt;
    logic [3:0] r_p;
    logic [3:0] r_t;
    logic [3:0] r_first_res;
    logic [3:0] r_second_res;
    logic [3:0] r_cd1;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic       out_free;
    logic [3:0] p_next;
    logic [3:0] t_next;
    logic [3:0] tp_next;
    logic [1:0] err;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_valid && (out_free || !i_cls.last);

    assign p_next  = mod11_add(r_p, i_cls.dval);
    assign t_next  = mod11_add(r_t, p_next);
    assign tp_next = mod11_add(t_next, p_next);

    always_comb begin
        if (!(r_fmt && i_cls.ok_char && i_cls.end_ok)) begin
            err = ERR_FORMAT;
        end else if (check_value(r_first_res) != r_cd1 ||
                     check_value(r_second_res) != i_cls.dval) begin
            err = ERR_CHECK;
        end else begin
            err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= 1'b1;
            r_dcnt       <= '0;
            r_p          <= '0;
            r_t          <= '0;
            r_first_res  <= '0;
            r_second_res <= '0;
            r_cd1        <= '0;
        end else if (o_pop) begin
            if (i_cls.last) begin
                r_fmt        <= 1'b1;
                r_dcnt       <= '0;
                r_p          <= '0;
                r_t          <= '0;
                r_first_res  <= '0;
                r_second_res <= '0;
                r_cd1        <= '0;
            end else begin
                if (!i_cls.ok_char) begin
                    r_fmt <= 1'b0;
                end
                if (i_cls.digit_ok && r_dcnt < DIGIT_TOTAL) begin
                    r_p    <= p_next;
                    r_t    <= t_next;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == IDX_FIRST) begin
                        r_first_res <= tp_next;
                    end
                    if (r_dcnt == IDX_SECOND) begin
                        r_second_res <= tp_next;
                        r_cd1        <= i_cls.dval;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out_word.valid_res  <= (err == ERR_OK);
            r_out_word.error_code <= err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
